[sv/ssd_pkg.sv]
// ============================================================================
// ssd_pkg
// Shared widths, latencies and types for the segment-to-segment distance block.
// ============================================================================
`default_nettype none

package ssd_pkg;

  localparam int COORD_W = 18;            // signed Q5.12 coordinate
  localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;    // product of two differences
  localparam int SUM_W   = PROD_W + 1;    // sum or difference of two products
  localparam int SQ_W    = PROD_W;        // squared distance, 24 fraction bits
  localparam int HALF_W  = SQ_W / 2;      // half of a cross magnitude
  localparam int DVD_W   = 2 * SQ_W;      // squared cross product
  localparam int QUO_W   = SQ_W;          // quotient bits
  localparam int ROOT_W  = SQ_W / 2;      // square root bits
  localparam int REM_W   = ROOT_W + 4;    // square root remainder
  localparam int DIST_W  = 19;            // unsigned Q7.12 distance

  localparam int IN_DATA_W  = 8 * COORD_W;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  localparam int PT_LAT    = 7 + QUO_W;   // point-to-segment unit
  localparam int MIN_LAT   = 2;           // minimum of four
  localparam int SQRT_LAT  = ROOT_W;      // one root bit a stage
  localparam int TOUCH_LAT = 4;           // intersection test
  localparam int CORE_LAT  = PT_LAT + MIN_LAT + SQRT_LAT;
  localparam int OUT_LAT   = CORE_LAT + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [SQ_W-1:0]    sq_t;

  function automatic sq_t sq_min(input sq_t a, input sq_t b);
    sq_min = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[sv/ssd_pt_seg.sv]
// ============================================================================
// ssd_pt_seg
// Pipelined squared distance from a point P to a segment AB.
// ============================================================================
`default_nettype none

module ssd_pt_seg (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire ssd_pkg::coord_t px_i,
  input  wire ssd_pkg::coord_t py_i,
  input  wire ssd_pkg::coord_t ax_i,
  input  wire ssd_pkg::coord_t ay_i,
  input  wire ssd_pkg::coord_t bx_i,
  input  wire ssd_pkg::coord_t by_i,
  output      ssd_pkg::sq_t    sq_o
);
  import ssd_pkg::*;

  diff_t vx_q, vy_q, wx_q, wy_q, ex_q, ey_q;
  prod_t wx2_q, wy2_q, ex2_q, ey2_q, vx2_q, vy2_q, vwx_q, vwy_q, cra_q, crb_q;
  sq_t   da_q, db_q, len3_q;
  sum_t  dot_q, cr_q;
  sq_t   best4_q, len4_q, ca_q;
  logic  inr4_q;
  logic [SQ_W-1:0] hh_q, hl_q, ll_q;
  sq_t   best5_q, len5_q;
  logic  inr5_q;
  logic [DVD_W-1:0] sq_sum;

  sq_t  rem_q  [0:QUO_W];
  sq_t  lo_q   [0:QUO_W];
  sq_t  quo_q  [0:QUO_W];
  sq_t  den_q  [0:QUO_W];
  sq_t  best_q [0:QUO_W];
  logic inr_q  [0:QUO_W];
  sq_t  rem_d  [1:QUO_W];
  sq_t  quo_d  [1:QUO_W];
  logic [SQ_W:0] trial [0:QUO_W-1];
  logic          ge    [0:QUO_W-1];
  sq_t  res_q;

  // Stages one to three: differences, products, sums.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q  <= DIFF_W'(bx_i) - DIFF_W'(ax_i);
      vy_q  <= DIFF_W'(by_i) - DIFF_W'(ay_i);
      wx_q  <= DIFF_W'(px_i) - DIFF_W'(ax_i);
      wy_q  <= DIFF_W'(py_i) - DIFF_W'(ay_i);
      ex_q  <= DIFF_W'(px_i) - DIFF_W'(bx_i);
      ey_q  <= DIFF_W'(py_i) - DIFF_W'(by_i);
      wx2_q <= PROD_W'(wx_q) * PROD_W'(wx_q);
      wy2_q <= PROD_W'(wy_q) * PROD_W'(wy_q);
      ex2_q <= PROD_W'(ex_q) * PROD_W'(ex_q);
      ey2_q <= PROD_W'(ey_q) * PROD_W'(ey_q);
      vx2_q <= PROD_W'(vx_q) * PROD_W'(vx_q);
      vy2_q <= PROD_W'(vy_q) * PROD_W'(vy_q);
      vwx_q <= PROD_W'(vx_q) * PROD_W'(wx_q);
      vwy_q <= PROD_W'(vy_q) * PROD_W'(wy_q);
      cra_q <= PROD_W'(vx_q) * PROD_W'(wy_q);
      crb_q <= PROD_W'(vy_q) * PROD_W'(wx_q);
      da_q   <= SQ_W'(wx2_q) + SQ_W'(wy2_q);
      db_q   <= SQ_W'(ex2_q) + SQ_W'(ey2_q);
      len3_q <= SQ_W'(vx2_q) + SQ_W'(vy2_q);
      dot_q  <= SUM_W'(vwx_q) + SUM_W'(vwy_q);
      cr_q   <= SUM_W'(cra_q) - SUM_W'(crb_q);
    end
  end

  // Stage four: projection range test and cross magnitude.
  // Stage five: partial products of the squared cross product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      best4_q <= sq_min(da_q, db_q);
      len4_q  <= len3_q;
      inr4_q  <= (len3_q != '0) && !dot_q[SUM_W-1] && (SQ_W'(dot_q) <= len3_q);
      ca_q    <= cr_q[SUM_W-1] ? SQ_W'(-cr_q) : SQ_W'(cr_q);
      hh_q    <= SQ_W'(ca_q[SQ_W-1:HALF_W]) * SQ_W'(ca_q[SQ_W-1:HALF_W]);
      hl_q    <= SQ_W'(ca_q[SQ_W-1:HALF_W]) * SQ_W'(ca_q[HALF_W-1:0]);
      ll_q    <= SQ_W'(ca_q[HALF_W-1:0]) * SQ_W'(ca_q[HALF_W-1:0]);
      best5_q <= best4_q;
      len5_q  <= len4_q;
      inr5_q  <= inr4_q;
    end
  end

  // The cross term appears twice, so it sits one bit above its half position.
  assign sq_sum = {hh_q, {SQ_W{1'b0}}}
                + {{(SQ_W-HALF_W-1){1'b0}}, hl_q, {(HALF_W+1){1'b0}}}
                + {{SQ_W{1'b0}}, ll_q};

  // Restoring division, one quotient bit a stage.
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k]   = {rem_q[k], lo_q[k][SQ_W-1]};
      ge[k]      = trial[k] >= {1'b0, den_q[k]};
      rem_d[k+1] = ge[k] ? SQ_W'(trial[k] - {1'b0, den_q[k]}) : SQ_W'(trial[k]);
      quo_d[k+1] = {quo_q[k][QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= sq_sum[DVD_W-1:SQ_W];
      lo_q[0]   <= sq_sum[SQ_W-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= len5_q;
      best_q[0] <= best5_q;
      inr_q[0]  <= inr5_q;
      for (int k = 1; k <= QUO_W; k++) begin
        rem_q[k]  <= rem_d[k];
        lo_q[k]   <= {lo_q[k-1][SQ_W-2:0], 1'b0};
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= den_q[k-1];
        best_q[k] <= best_q[k-1];
        inr_q[k]  <= inr_q[k-1];
      end
      res_q <= (inr_q[QUO_W] && (quo_q[QUO_W] < best_q[QUO_W])) ?
               quo_q[QUO_W] : best_q[QUO_W];
    end
  end

  assign sq_o = res_q;

endmodule

`default_nettype wire

[sv/ssd_touch.sv]
// ============================================================================
// ssd_touch
// Pipelined exact test for two segments crossing, touching or overlapping.
// ============================================================================
`default_nettype none

module ssd_touch (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire ssd_pkg::coord_t ax_i,
  input  wire ssd_pkg::coord_t ay_i,
  input  wire ssd_pkg::coord_t bx_i,
  input  wire ssd_pkg::coord_t by_i,
  input  wire ssd_pkg::coord_t cx_i,
  input  wire ssd_pkg::coord_t cy_i,
  input  wire ssd_pkg::coord_t dx_i,
  input  wire ssd_pkg::coord_t dy_i,
  output      logic            touch_o
);
  import ssd_pkg::*;

  diff_t  ux_q, uy_q, vx_q, vy_q, cax_q, cay_q, dax_q, day_q;
  diff_t  acx_q, acy_q, bcx_q, bcy_q;
  coord_t lox_q, hix_q, loy_q, hiy_q;
  prod_t  p_q [0:9];
  logic   ovx_q, ovy_q, ov3_q;
  sum_t   dd_q, c1_q, c2_q, c3_q, c4_q;
  logic   tch_q;
  logic   par, col, s1, s2;

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    cmin = (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    cmax = (a > b) ? a : b;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q  <= DIFF_W'(bx_i) - DIFF_W'(ax_i);
      uy_q  <= DIFF_W'(by_i) - DIFF_W'(ay_i);
      vx_q  <= DIFF_W'(dx_i) - DIFF_W'(cx_i);
      vy_q  <= DIFF_W'(dy_i) - DIFF_W'(cy_i);
      cax_q <= DIFF_W'(cx_i) - DIFF_W'(ax_i);
      cay_q <= DIFF_W'(cy_i) - DIFF_W'(ay_i);
      dax_q <= DIFF_W'(dx_i) - DIFF_W'(ax_i);
      day_q <= DIFF_W'(dy_i) - DIFF_W'(ay_i);
      acx_q <= DIFF_W'(ax_i) - DIFF_W'(cx_i);
      acy_q <= DIFF_W'(ay_i) - DIFF_W'(cy_i);
      bcx_q <= DIFF_W'(bx_i) - DIFF_W'(cx_i);
      bcy_q <= DIFF_W'(by_i) - DIFF_W'(cy_i);
      lox_q <= cmax(cmin(ax_i, bx_i), cmin(cx_i, dx_i));
      hix_q <= cmin(cmax(ax_i, bx_i), cmax(cx_i, dx_i));
      loy_q <= cmax(cmin(ay_i, by_i), cmin(cy_i, dy_i));
      hiy_q <= cmin(cmax(ay_i, by_i), cmax(cy_i, dy_i));

      p_q[0] <= PROD_W'(ux_q) * PROD_W'(vy_q);
      p_q[1] <= PROD_W'(uy_q) * PROD_W'(vx_q);
      p_q[2] <= PROD_W'(ux_q) * PROD_W'(cay_q);
      p_q[3] <= PROD_W'(uy_q) * PROD_W'(cax_q);
      p_q[4] <= PROD_W'(ux_q) * PROD_W'(day_q);
      p_q[5] <= PROD_W'(uy_q) * PROD_W'(dax_q);
      p_q[6] <= PROD_W'(vx_q) * PROD_W'(acy_q);
      p_q[7] <= PROD_W'(vy_q) * PROD_W'(acx_q);
      p_q[8] <= PROD_W'(vx_q) * PROD_W'(bcy_q);
      p_q[9] <= PROD_W'(vy_q) * PROD_W'(bcx_q);
      ovx_q  <= lox_q <= hix_q;
      ovy_q  <= loy_q <= hiy_q;

      dd_q  <= SUM_W'(p_q[0]) - SUM_W'(p_q[1]);
      c1_q  <= SUM_W'(p_q[2]) - SUM_W'(p_q[3]);
      c2_q  <= SUM_W'(p_q[4]) - SUM_W'(p_q[5]);
      c3_q  <= SUM_W'(p_q[6]) - SUM_W'(p_q[7]);
      c4_q  <= SUM_W'(p_q[8]) - SUM_W'(p_q[9]);
      ov3_q <= ovx_q && ovy_q;

      tch_q <= par ? (col && ov3_q) : (s1 && s2);
    end
  end

  // Sign products at or below zero: either term is zero or the signs differ.
  always_comb begin
    par = dd_q == '0;
    col = (c1_q == '0) && (c2_q == '0) && (c3_q == '0) && (c4_q == '0);
    s1  = (c1_q == '0) || (c2_q == '0) || (c1_q[SUM_W-1] != c2_q[SUM_W-1]);
    s2  = (c3_q == '0) || (c4_q == '0) || (c3_q[SUM_W-1] != c4_q[SUM_W-1]);
  end

  assign touch_o = tch_q;

endmodule

`default_nettype wire

[sv/ssd_sqrt.sv]
// ============================================================================
// ssd_sqrt
// Pipelined integer square root, one root bit a stage.
// ============================================================================
`default_nettype none

module ssd_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire ssd_pkg::sq_t               x_i,
  output      logic [ssd_pkg::ROOT_W-1:0] root_o
);
  import ssd_pkg::*;

  sq_t               x_s    [1:ROOT_W];
  logic [REM_W-1:0]  rem_s  [1:ROOT_W];
  logic [ROOT_W-1:0] root_s [1:ROOT_W];
  sq_t               x_c    [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_c  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_c [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_t  [0:ROOT_W-1];
  logic [REM_W-1:0]  trial  [0:ROOT_W-1];
  logic              ge     [0:ROOT_W-1];

  // Stage zero works on the incoming value; later stages on their registers.
  always_comb begin
    x_c[0]    = x_i;
    rem_c[0]  = '0;
    root_c[0] = '0;
    for (int j = 1; j < ROOT_W; j++) begin
      x_c[j]    = x_s[j];
      rem_c[j]  = rem_s[j];
      root_c[j] = root_s[j];
    end
    for (int j = 0; j < ROOT_W; j++) begin
      rem_t[j] = {rem_c[j][REM_W-3:0], x_c[j][SQ_W-1 -: 2]};
      trial[j] = REM_W'({root_c[j], 2'b01});
      ge[j]    = rem_t[j] >= trial[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < ROOT_W; j++) begin
        x_s[j+1]    <= {x_c[j][SQ_W-3:0], 2'b00};
        rem_s[j+1]  <= ge[j] ? (rem_t[j] - trial[j]) : rem_t[j];
        root_s[j+1] <= {root_c[j][ROOT_W-2:0], ge[j]};
      end
    end
  end

  assign root_o = root_s[ROOT_W];

endmodule

`default_nettype wire

[sv/segment_segment_distance.sv]
// ============================================================================
// segment_segment_distance
// Shortest distance between two 2-D segments, with a touch flag.
// ============================================================================
//
// Channel   Dir  Contents (lowest bits first)
// s_axis    in   A.x A.y B.x B.y C.x C.y D.x D.y, signed Q5.12, 18 bits each
// m_axis    out  tdata: distance, unsigned Q7.12; tuser: touching
//
// One request enters per cycle while the output does not stall. A result
// passes through the point-to-segment units (their division takes one
// quotient bit per stage), the minimum of four, the square root (one root
// bit per stage) and one output register. Reset clears the valid bits and
// the valid bit of the input skid register only. When the output stalls, the
// whole pipeline holds; the skid register still takes one more request then.
// ============================================================================
`default_nettype none

module segment_segment_distance (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // A.x, A.y, B.x, B.y, C.x, C.y, D.x, D.y
  input  wire logic [ssd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // distance, then zero fill
  output      logic [ssd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // touching
  output      logic                              m_axis_tuser
);
  import ssd_pkg::*;

  logic                 en;
  logic                 acc;
  logic                 skid_v_q, skid_v_d;
  logic [IN_DATA_W-1:0] skid_data_q;
  logic [IN_DATA_W-1:0] pipe_data;
  logic                 pipe_vld;
  logic                 vld_q [0:OUT_LAT-1];
  coord_t               ax, ay, bx, by, cx, cy, dx, dy;
  sq_t                  d0, d1, d2, d3;
  sq_t                  m01_q, m23_q, mn_q;
  logic [ROOT_W-1:0]    root;
  logic                 touch;
  logic                 tch_q [0:CORE_LAT-TOUCH_LAT-1];
  logic [DIST_W-1:0]    dist_q;
  logic                 touch_q;

  // The pipeline moves whenever the output register is empty or drained.
  assign en            = m_axis_tready || !vld_q[OUT_LAT-1];
  assign s_axis_tready = !skid_v_q;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // A request held in the skid register goes in ahead of anything new.
  assign pipe_data = skid_v_q ? skid_data_q : s_axis_tdata;
  assign pipe_vld  = skid_v_q || acc;

  always_comb begin
    skid_v_d = skid_v_q;
    if (en) begin
      skid_v_d = 1'b0;
    end else if (acc) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !en) begin
      skid_data_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OUT_LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pipe_vld;
      for (int i = 1; i < OUT_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  assign ax = coord_t'(pipe_data[0*COORD_W +: COORD_W]);
  assign ay = coord_t'(pipe_data[1*COORD_W +: COORD_W]);
  assign bx = coord_t'(pipe_data[2*COORD_W +: COORD_W]);
  assign by = coord_t'(pipe_data[3*COORD_W +: COORD_W]);
  assign cx = coord_t'(pipe_data[4*COORD_W +: COORD_W]);
  assign cy = coord_t'(pipe_data[5*COORD_W +: COORD_W]);
  assign dx = coord_t'(pipe_data[6*COORD_W +: COORD_W]);
  assign dy = coord_t'(pipe_data[7*COORD_W +: COORD_W]);

  // The four endpoint-to-segment distances run side by side.
  ssd_pt_seg u_pt_a (.clk_i, .en_i(en), .px_i(ax), .py_i(ay),
                     .ax_i(cx), .ay_i(cy), .bx_i(dx), .by_i(dy), .sq_o(d0));
  ssd_pt_seg u_pt_b (.clk_i, .en_i(en), .px_i(bx), .py_i(by),
                     .ax_i(cx), .ay_i(cy), .bx_i(dx), .by_i(dy), .sq_o(d1));
  ssd_pt_seg u_pt_c (.clk_i, .en_i(en), .px_i(cx), .py_i(cy),
                     .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_i(by), .sq_o(d2));
  ssd_pt_seg u_pt_d (.clk_i, .en_i(en), .px_i(dx), .py_i(dy),
                     .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_i(by), .sq_o(d3));

  ssd_touch u_touch (.clk_i, .en_i(en), .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_i(by),
                     .cx_i(cx), .cy_i(cy), .dx_i(dx), .dy_i(dy), .touch_o(touch));

  always_ff @(posedge clk_i) begin
    if (en) begin
      m01_q <= sq_min(d0, d1);
      m23_q <= sq_min(d2, d3);
      mn_q  <= sq_min(m01_q, m23_q);
    end
  end

  ssd_sqrt u_sqrt (.clk_i, .en_i(en), .x_i(mn_q), .root_o(root));

  // The touch flag is ready early and waits here for the distance.
  always_ff @(posedge clk_i) begin
    if (en) begin
      tch_q[0] <= touch;
      for (int i = 1; i < CORE_LAT - TOUCH_LAT; i++) tch_q[i] <= tch_q[i-1];
    end
  end

  // The root of a 38-bit value never exceeds the 19-bit distance range, so
  // the root fits the distance without saturation with these coordinate widths.
  always_ff @(posedge clk_i) begin
    if (en) begin
      touch_q <= tch_q[CORE_LAT-TOUCH_LAT-1];
      dist_q  <= tch_q[CORE_LAT-TOUCH_LAT-1] ? '0 : DIST_W'(root);
    end
  end

  assign m_axis_tvalid = vld_q[OUT_LAT-1];
  assign m_axis_tdata  = OUT_DATA_W'(dist_q);
  assign m_axis_tuser  = touch_q;

  // Segments that touch always report zero distance.
  a_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("touching result with nonzero distance");

  // A request parked in the skid register drains as soon as the pipe moves.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && en) |=> !skid_v_q)
    else $error("skid register did not drain");

  // A request parked in the skid register stays there while the pipe is stalled.
  a_skid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !en) |=> skid_v_q)
    else $error("skid register lost a request");

endmodule

`default_nettype wire
